FILE: sv/numeric_dtype_converter_assert.svh
// assertion macros shared by the dtype converter rtl
`ifndef NUMERIC_DTYPE_CONVERTER_ASSERT_SVH
`define NUMERIC_DTYPE_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define NDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define NDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/ndc_pkg.sv
// types, codes and helper functions of the dtype converter
`default_nettype none
package ndc_pkg;

	localparam int unsigned EXP_W = 12;

	localparam logic [3:0] TY_F16  = 4'd0;
	localparam logic [3:0] TY_F32  = 4'd1;
	localparam logic [3:0] TY_F64  = 4'd2;
	localparam logic [3:0] TY_I8   = 4'd3;
	localparam logic [3:0] TY_I16  = 4'd4;
	localparam logic [3:0] TY_I32  = 4'd5;
	localparam logic [3:0] TY_I64  = 4'd6;
	localparam logic [3:0] TY_U8   = 4'd7;
	localparam logic [3:0] TY_U16  = 4'd8;
	localparam logic [3:0] TY_U32  = 4'd9;
	localparam logic [3:0] TY_U64  = 4'd10;
	localparam logic [3:0] TY_BOOL = 4'd11;

	localparam logic [1:0] FAM_FLT  = 2'd0;
	localparam logic [1:0] FAM_SINT = 2'd1;
	localparam logic [1:0] FAM_UINT = 2'd2;
	localparam logic [1:0] FAM_BOOL = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SIGN  = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	typedef enum logic [2:0] {
		OP_ZERO,
		OP_PASS,
		OP_BOOL,
		OP_FLT,
		OP_F2I
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] src;
		logic [3:0] dst;
		logic [1:0] status;
	} ndc_cfg_t;

	// unpacked element: value = sig * 2^(exp-63)
	typedef struct packed {
		logic                    last;
		logic                    sign;
		logic                    nan;
		logic                    inf;
		logic signed [EXP_W-1:0] exp;
		logic [63:0]             sig;
		logic [63:0]             bypass;
	} ndc_unp_t;

	typedef struct packed {
		logic                    last;
		logic                    sign;
		logic                    nan;
		logic                    inf;
		logic                    zero;
		logic                    big;
		logic signed [EXP_W-1:0] exp;
		logic [52:0]             man;
		logic [63:0]             mag;
		logic [63:0]             bypass;
	} ndc_rnd_t;

	function automatic logic [1:0] type_family(input logic [3:0] t);
		logic [1:0] f;
		case (t)
			TY_F16, TY_F32, TY_F64: f = FAM_FLT;
			TY_I8, TY_I16, TY_I32, TY_I64: f = FAM_SINT;
			TY_BOOL: f = FAM_BOOL;
			default: f = FAM_UINT;
		endcase
		return f;
	endfunction

	function automatic logic [1:0] type_rank(input logic [3:0] t);
		logic [1:0] r;
		case (t)
			TY_F32, TY_I16, TY_U16: r = 2'd1;
			TY_F64, TY_I32, TY_U32: r = 2'd2;
			TY_I64, TY_U64: r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] type_width(input logic [3:0] t);
		logic [6:0] w;
		case (t)
			TY_I8, TY_U8: w = 7'd8;
			TY_F16, TY_I16, TY_U16: w = 7'd16;
			TY_F32, TY_I32, TY_U32: w = 7'd32;
			TY_BOOL: w = 7'd1;
			default: w = 7'd64;
		endcase
		return w;
	endfunction

	// a shift by 64 gives zero, so the mask is all ones then
	function automatic logic [63:0] width_mask(input logic [6:0] w);
		return (64'd1 << w) - 64'd1;
	endfunction

	function automatic logic [63:0] normalize(input logic [3:0] t, input logic [63:0] v);
		logic [6:0]  w;
		logic [63:0] m;
		logic [63:0] x;
		w = type_width(t);
		m = width_mask(w);
		x = v & m;
		case (type_family(t))
			FAM_SINT: begin
				if (x[6'(w - 7'd1)])
					x = x | ~m;
			end
			FAM_BOOL: x = {63'd0, v[0]};
			default: x = v & m;
		endcase
		return x;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ndc_cfg.sv
// type registers and decode of the conversion pair
`default_nettype none
module ndc_cfg import ndc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	output ndc_cfg_t   cfg
);

	logic [3:0] src_q;
	logic [3:0] dst_q;
	logic [1:0] sf;
	logic [1:0] tf;
	logic [1:0] sfe;
	logic       allowed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= TY_F32;
			dst_q <= TY_F32;
		end else if (cfg_write) begin
			if (cfg_index == REG_SOURCE)
				src_q <= cfg_data;
			else
				dst_q <= cfg_data;
		end
	end

	always_comb begin
		sf = type_family(src_q);
		tf = type_family(dst_q);
		sfe = (dst_q == TY_BOOL) ? tf : sf;
		if (src_q == dst_q || dst_q == TY_BOOL || src_q == TY_BOOL)
			allowed = 1'b1;
		else if ((sf == FAM_FLT && tf == FAM_SINT) || (sf == FAM_SINT && tf == FAM_FLT))
			allowed = 1'b1;
		else if (sf != tf)
			allowed = 1'b0;
		else
			allowed = type_rank(dst_q) >= type_rank(src_q);
	end

	always_comb begin
		cfg.src = src_q;
		cfg.dst = dst_q;
		cfg.status = ST_OK;
		cfg.op = OP_PASS;
		if (src_q > TY_BOOL || dst_q > TY_BOOL) begin
			cfg.op = OP_ZERO;
			cfg.status = ST_TRUNC;
		end else if ((sfe == FAM_UINT || tf == FAM_UINT) && sfe != tf) begin
			cfg.op = OP_ZERO;
			cfg.status = ST_SIGN;
		end else if (!allowed) begin
			cfg.op = OP_ZERO;
			cfg.status = ST_TRUNC;
		end else if (src_q == dst_q) begin
			cfg.op = OP_PASS;
		end else if (dst_q == TY_BOOL) begin
			cfg.op = OP_BOOL;
		end else if (tf == FAM_FLT) begin
			cfg.op = OP_FLT;
		end else if (tf == FAM_SINT && sf == FAM_FLT) begin
			cfg.op = OP_F2I;
		end else begin
			// integer widening and bool to signed
			cfg.op = OP_PASS;
		end
	end

endmodule
`default_nettype wire

FILE: sv/ndc_unpack.sv
// stage 1: splits the source element into sign, exponent and significand
`default_nettype none
module ndc_unpack import ndc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ndc_cfg_t    cfg,
	input  logic        in_valid,
	input  logic [63:0] value_bits,
	input  logic        is_last,
	input  logic        next_ready,
	output logic        ready,
	output logic        valid_s1,
	output ndc_unp_t    data_s1
);

	ndc_unp_t    d;
	logic [63:0] norm;
	logic [63:0] fmask;
	logic [4:0]  e5;
	logic [7:0]  e8;
	logic [10:0] e11;
	logic        nz;

	always_comb begin
		norm = normalize(cfg.src, value_bits);
		fmask = width_mask(type_width(cfg.src));
		// floats are nonzero regardless of sign
		if (type_family(cfg.src) == FAM_FLT)
			fmask = fmask >> 1;
		nz = (value_bits & fmask) != 64'd0;
		e5 = value_bits[14:10];
		e8 = value_bits[30:23];
		e11 = value_bits[62:52];
		d.last = is_last;
		d.sign = 1'b0;
		d.nan = 1'b0;
		d.inf = 1'b0;
		d.exp = 12'sd63;
		d.sig = norm;
		case (cfg.src)
			TY_F16: begin
				d.sign = value_bits[15];
				d.nan = (e5 == 5'h1F) && (value_bits[9:0] != 10'd0);
				d.inf = (e5 == 5'h1F) && (value_bits[9:0] == 10'd0);
				d.sig = {e5 != 5'd0, value_bits[9:0], 53'd0};
				d.exp = (e5 == 5'd0) ? -12'sd14 : $signed({7'd0, e5}) - 12'sd15;
			end
			TY_F32: begin
				d.sign = value_bits[31];
				d.nan = (e8 == 8'hFF) && (value_bits[22:0] != 23'd0);
				d.inf = (e8 == 8'hFF) && (value_bits[22:0] == 23'd0);
				d.sig = {e8 != 8'd0, value_bits[22:0], 40'd0};
				d.exp = (e8 == 8'd0) ? -12'sd126 : $signed({4'd0, e8}) - 12'sd127;
			end
			TY_F64: begin
				d.sign = value_bits[63];
				d.nan = (e11 == 11'h7FF) && (value_bits[51:0] != 52'd0);
				d.inf = (e11 == 11'h7FF) && (value_bits[51:0] == 52'd0);
				d.sig = {e11 != 11'd0, value_bits[51:0], 11'd0};
				d.exp = (e11 == 11'd0) ? -12'sd1022 : $signed({1'b0, e11}) - 12'sd1023;
			end
			default: begin
				d.sign = (type_family(cfg.src) == FAM_SINT) && norm[63];
				d.sig = d.sign ? (64'd0 - norm) : norm;
			end
		endcase
		case (cfg.op)
			OP_PASS: d.bypass = norm;
			OP_BOOL: d.bypass = {63'd0, nz};
			default: d.bypass = 64'd0;
		endcase
	end

	assign ready = !valid_s1 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ready)
			data_s1 <= d;
	end

endmodule
`default_nettype wire

FILE: sv/ndc_norm.sv
// stages 2 and 3: leading zero count, then normalizing left shift
`default_nettype none
module ndc_norm import ndc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	input  ndc_unp_t up,
	input  logic     next_ready,
	output logic     ready,
	output logic     valid_s3,
	output ndc_unp_t data_s3
);

	logic     valid_s2;
	ndc_unp_t data_s2;
	logic [6:0] lz_s2;
	logic [6:0] lz;
	logic     ready2;
	logic     ready3;
	ndc_unp_t d3;

	always_comb begin
		lz = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (up.sig[i])
				lz = 7'(63 - i);
		end
	end

	// a zero significand keeps lz[5:0] at zero and stays zero
	always_comb begin
		d3 = data_s2;
		d3.sig = data_s2.sig << lz_s2[5:0];
		d3.exp = $signed(data_s2.exp) - $signed({5'd0, lz_s2});
	end

	assign ready3 = !valid_s3 || next_ready;
	assign ready2 = !valid_s2 || ready3;
	assign ready = ready2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready2)
				valid_s2 <= up_valid;
			if (ready3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2) begin
			data_s2 <= up;
			lz_s2 <= lz;
		end
		if (ready3)
			data_s3 <= d3;
	end

endmodule
`default_nettype wire

FILE: sv/ndc_round.sv
// stages 4 and 5: rounding to binary64 and integer shift, then target packing
`default_nettype none
module ndc_round import ndc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ndc_cfg_t    cfg,
	input  logic        up_valid,
	input  ndc_unp_t    up,
	input  logic        out_stall,
	output logic        ready,
	output logic        out_valid,
	output logic [63:0] result_bits,
	output logic [1:0]  status,
	output logic        last_out
);

	logic     valid_s4;
	ndc_rnd_t data_s4;
	ndc_rnd_t d4;
	logic     ready4;
	logic     ready5;
	logic [53:0] sum54;
	logic        up53;

	logic [63:0] res_s5;
	logic [1:0]  status_s5;
	logic        last_s5;

	logic [63:0] res;
	logic [1:0]  st;
	logic [63:0] f64w;
	logic [63:0] f32w;
	logic [63:0] f16w;
	logic [63:0] intw;
	logic        sat;
	logic [24:0] s25;
	logic        up24;
	logic [11:0] s12;
	logic        up11;
	logic signed [EXP_W-1:0] e_f;
	logic signed [EXP_W-1:0] e_h;
	logic [63:0] lim;

	// round the significand to 53 bits, nearest even
	always_comb begin
		up53 = up.sig[10] && ((up.sig[9:0] != 10'd0) || up.sig[11]);
		sum54 = {1'b0, up.sig[63:11]} + {53'd0, up53};
		d4.last = up.last;
		d4.sign = up.sign;
		d4.nan = up.nan;
		d4.inf = up.inf;
		d4.zero = up.sig == 64'd0;
		d4.big = $signed(up.exp) > 12'sd63;
		d4.man = sum54[53] ? sum54[53:1] : sum54[52:0];
		d4.exp = $signed(up.exp) + $signed({11'd0, sum54[53]});
		if ($signed(up.exp) < 12'sd0)
			d4.mag = 64'd0;
		else
			d4.mag = up.sig >> (6'd63 - up.exp[5:0]);
		d4.bypass = up.bypass;
	end

	always_comb begin
		// binary64
		if (data_s4.nan)
			f64w = {data_s4.sign, 11'h7FF, 1'b1, data_s4.man[50:0]};
		else if (data_s4.inf)
			f64w = {data_s4.sign, 11'h7FF, 52'd0};
		else if (data_s4.zero)
			f64w = {data_s4.sign, 63'd0};
		else
			f64w = {data_s4.sign, 11'(data_s4.exp + 12'sd1023), data_s4.man[51:0]};

		// binary32
		up24 = data_s4.man[28] && ((data_s4.man[27:0] != 28'd0) || data_s4.man[29]);
		s25 = {1'b0, data_s4.man[52:29]} + {24'd0, up24};
		e_f = $signed(data_s4.exp) + $signed({11'd0, s25[24]});
		if (data_s4.nan)
			f32w = {32'd0, data_s4.sign, 8'hFF, 1'b1, data_s4.man[50:29]};
		else if (data_s4.inf)
			f32w = {32'd0, data_s4.sign, 8'hFF, 23'd0};
		else if (data_s4.zero)
			f32w = {32'd0, data_s4.sign, 31'd0};
		else
			f32w = {32'd0, data_s4.sign, 8'(e_f + 12'sd127),
				s25[24] ? 23'd0 : s25[22:0]};

		// binary16, overflow goes to infinity
		up11 = data_s4.man[41] && ((data_s4.man[40:0] != 41'd0) || data_s4.man[42]);
		s12 = {1'b0, data_s4.man[52:42]} + {11'd0, up11};
		e_h = $signed(data_s4.exp) + $signed({11'd0, s12[11]});
		if (data_s4.nan)
			f16w = {48'd0, data_s4.sign, 5'h1F, 1'b1, data_s4.man[50:42]};
		else if (data_s4.inf || e_h > 12'sd15)
			f16w = {48'd0, data_s4.sign, 5'h1F, 10'd0};
		else if (data_s4.zero)
			f16w = {48'd0, data_s4.sign, 15'd0};
		else
			f16w = {48'd0, data_s4.sign, 5'(e_h + 12'sd15),
				s12[11] ? 10'd0 : s12[9:0]};

		// float to signed with saturation
		lim = 64'd1 << (type_width(cfg.dst) - 7'd1);
		sat = 1'b0;
		if (data_s4.nan) begin
			sat = 1'b1;
			intw = 64'd0;
		end else if (data_s4.inf || data_s4.big) begin
			sat = 1'b1;
			intw = data_s4.sign ? (64'd0 - lim) : (lim - 64'd1);
		end else if (!data_s4.sign) begin
			sat = data_s4.mag >= lim;
			intw = sat ? (lim - 64'd1) : data_s4.mag;
		end else begin
			sat = data_s4.mag > lim;
			intw = sat ? (64'd0 - lim) : (64'd0 - data_s4.mag);
		end

		st = cfg.status;
		case (cfg.op)
			OP_FLT: begin
				case (cfg.dst)
					TY_F16: res = f16w;
					TY_F32: res = f32w;
					default: res = f64w;
				endcase
			end
			OP_F2I: begin
				res = intw;
				st = sat ? ST_SAT : ST_OK;
			end
			default: res = data_s4.bypass;
		endcase
	end

	assign ready5 = !out_valid || !out_stall;
	assign ready4 = !valid_s4 || ready5;
	assign ready = ready4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready4)
				valid_s4 <= up_valid;
			if (ready5)
				out_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready4)
			data_s4 <= d4;
		if (ready5) begin
			res_s5 <= res;
			status_s5 <= st;
			last_s5 <= data_s4.last;
		end
	end

	assign result_bits = res_s5;
	assign status = status_s5;
	assign last_out = last_s5;

endmodule
`default_nettype wire

FILE: sv/numeric_dtype_converter.sv
// pipeline: five register stages: unpack, leading zero count, normalizing shift, rounding, target packing
// throughput: one item per cycle while the output is not stalled; each of the five stages holds one item
// stalls propagate per stage, so bubbles are squeezed out while the output waits
// reset clears every stage valid bit and sets both type registers to binary32
`default_nettype none
`include "numeric_dtype_converter_assert.svh"
module numeric_dtype_converter import ndc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value_bits,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bits,
	output logic [1:0]  status,
	output logic        last_out
);

	ndc_cfg_t cfg;
	logic     unp_ready;
	logic     norm_ready;
	logic     rnd_ready;
	logic     valid_s1;
	ndc_unp_t data_s1;
	logic     valid_s3;
	ndc_unp_t data_s3;

	ndc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ndc_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.value_bits (value_bits),
		.is_last    (is_last),
		.next_ready (norm_ready),
		.ready      (unp_ready),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	ndc_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s1),
		.up         (data_s1),
		.next_ready (rnd_ready),
		.ready      (norm_ready),
		.valid_s3   (valid_s3),
		.data_s3    (data_s3)
	);

	ndc_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.up_valid    (valid_s3),
		.up          (data_s3),
		.out_stall   (out_stall),
		.ready       (rnd_ready),
		.out_valid   (out_valid),
		.result_bits (result_bits),
		.status      (status),
		.last_out    (last_out)
	);

	assign in_stall = !unp_ready;

	`NDC_ASSERT_IMP(a_sat_only_f2i, clk, arst_n, out_valid && status == ST_SAT, cfg.op == OP_F2I, "saturation flag outside float to integer")
	`NDC_ASSERT_IMP(a_reject_zero, clk, arst_n, out_valid && cfg.op == OP_ZERO, result_bits == 64'd0, "rejected pair gave nonzero result")
	`NDC_ASSERT_IMP(a_bool_result, clk, arst_n, out_valid && cfg.dst == TY_BOOL, result_bits[63:1] == 63'd0, "bool result wider than one bit")
	`NDC_ASSERT_IMP(a_drain_accepts, clk, arst_n, out_valid && !out_stall, !in_stall, "pipe draining but input stalled")
	`NDC_ASSERT_NXT(a_src_write, clk, arst_n, cfg_write && cfg_index == REG_SOURCE, cfg.src == $past(cfg_data), "source type write lost")

endmodule
`default_nettype wire

FILE: dv/tb_numeric_dtype_converter.sv
// testbench for the numeric dtype converter: bit-exact prediction over all type pairs
`timescale 1ns / 1ps
module tb_numeric_dtype_converter import ndc_pkg::*;;

	typedef struct {
		bit [63:0] bits;
		bit [1:0]  st;
		bit        last;
	} conv_result_t;

	class conv_scoreboard;
		conv_result_t due_q[$];
		logic [3:0]   src_ty;
		logic [3:0]   dst_ty;
		int           mismatches;
		int           results_seen;
		logic [1:0]   fam_of[12] = '{FAM_FLT, FAM_FLT, FAM_FLT, FAM_SINT, FAM_SINT, FAM_SINT,
			FAM_SINT, FAM_UINT, FAM_UINT, FAM_UINT, FAM_UINT, FAM_BOOL};
		int           rank_of[12] = '{0, 1, 2, 0, 1, 2, 3, 0, 1, 2, 3, 0};
		int           width_of[12] = '{16, 32, 64, 8, 16, 32, 64, 8, 16, 32, 64, 1};

		function new();
			src_ty = TY_F32;
			dst_ty = TY_F32;
		endfunction

		function void set_types(logic [3:0] s, logic [3:0] t);
			src_ty = s;
			dst_ty = t;
		endfunction

		function bit [63:0] lmask(int w);
			return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		endfunction

		function bit [63:0] sext(bit [63:0] v, int w);
			bit [63:0] m;
			bit [63:0] x;
			m = lmask(w);
			x = v & m;
			if (w < 64 && x[w-1])
				x = x | ~m;
			return x;
		endfunction

		// integer magnitude to binary64, round to nearest even
		function bit [63:0] int_to_dbl(bit neg, bit [63:0] mag);
			int        p;
			int        sh;
			bit [63:0] q;
			bit [63:0] rem;
			bit [63:0] half;
			// zero keeps its sign
			if (mag == 0)
				return {neg, 63'd0};
			p = 0;
			for (int i = 0; i < 64; i++)
				if (mag[i])
					p = i;
			if (p <= 52) begin
				q = mag << (52 - p);
				return {neg, 11'(p + 1023), q[51:0]};
			end
			sh = p - 52;
			q = mag >> sh;
			rem = mag & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 64'd1;
			if (q[53]) begin
				q = q >> 1;
				p = p + 1;
			end
			return {neg, 11'(p + 1023), q[51:0]};
		endfunction

		function bit [63:0] src_to_dbl(logic [3:0] t, bit [63:0] v);
			bit [63:0] x;
			bit [63:0] d;
			case (t)
				TY_F16: begin
					if (v[14:10] == 5'd0) begin
						// subnormal: exact integer scaled by 2^-24
						d = int_to_dbl(v[15], {54'd0, v[9:0]});
						if (v[9:0] != 0)
							d[62:52] = d[62:52] - 11'd24;
						return d;
					end
					if (v[14:10] == 5'h1F)
						return {v[15], 11'h7FF, v[9:0], 42'd0} |
							((v[9:0] != 0) ? (64'd1 << 51) : 64'd0);
					return {v[15], 11'(v[14:10] + 11'd1008), v[9:0], 42'd0};
				end
				TY_F32: begin
					if (v[30:23] == 8'd0) begin
						d = int_to_dbl(v[31], {41'd0, v[22:0]});
						if (v[22:0] != 0)
							d[62:52] = d[62:52] - 11'd149;
						return d;
					end
					if (v[30:23] == 8'hFF)
						return {v[31], 11'h7FF, v[22:0], 29'd0} |
							((v[22:0] != 0) ? (64'd1 << 51) : 64'd0);
					return {v[31], 11'(v[30:23] + 11'd896), v[22:0], 29'd0};
				end
				TY_F64: return v;
				TY_BOOL: return v[0] ? 64'h3FF0_0000_0000_0000 : 64'd0;
				default: begin
					if (fam_of[t] == FAM_SINT) begin
						x = sext(v, width_of[t]);
						return x[63] ? int_to_dbl(1'b1, 64'd0 - x) : int_to_dbl(1'b0, x);
					end
					return int_to_dbl(1'b0, v & lmask(width_of[t]));
				end
			endcase
		endfunction

		// binary64 to a narrower float, round to nearest even
		function bit [63:0] dbl_to_narrow(bit [63:0] b, int bias, int ebits, int mw);
			bit [63:0] sb;
			bit [63:0] eall;
			bit [63:0] m;
			bit [63:0] q;
			bit [63:0] rem;
			bit [63:0] half;
			int        e;
			int        shift;
			sb = b[63] ? (64'd1 << (ebits + mw)) : 64'd0;
			eall = ((64'd1 << ebits) - 64'd1) << mw;
			if (b[62:52] == 11'h7FF)
				return (b[51:0] != 0) ?
					(sb | eall | (64'd1 << (mw - 1)) | (64'(b[51:0]) >> (52 - mw))) :
					(sb | eall);
			if (b[62:52] == 11'd0)
				return sb;
			e = int'(b[62:52]) - 1023;
			if (e < -bias - mw)
				return sb;
			if (e > bias)
				return sb | eall;
			m = {12'd1, b[51:0]};
			shift = (e >= 1 - bias) ? (52 - mw) : (52 - (e + bias - 1 + mw));
			q = m >> shift;
			rem = m & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 64'd1;
			if (e >= 1 - bias)
				return sb | ((64'(e + bias - 1) << mw) + q);
			return sb | q;
		endfunction

		function bit [63:0] dbl_to_int(bit [63:0] b, int w, bit is_signed, inout bit [1:0] st);
			real       d;
			real       hi;
			bit [63:0] mag;
			int        e;
			if (b[62:52] == 11'h7FF && b[51:0] != 0) begin
				st = ST_SAT;
				return 64'd0;
			end
			d = $bitstoreal(b);
			if (is_signed) begin
				hi = $bitstoreal({1'b0, 11'(1023 + w - 1), 52'd0});
				if (d >= hi) begin
					st = ST_SAT;
					return (64'd1 << (w - 1)) - 64'd1;
				end
				if (d < -hi && !(d > -hi - 1.0)) begin
					st = ST_SAT;
					return 64'd0 - (64'd1 << (w - 1));
				end
			end else begin
				hi = $bitstoreal({1'b0, 11'(1023 + w), 52'd0});
				if (d >= hi) begin
					st = ST_SAT;
					return lmask(w);
				end
				if (d <= -1.0) begin
					st = ST_SAT;
					return 64'd0;
				end
				if (d < 0.0)
					return 64'd0;
			end
			// truncate toward zero
			e = int'(b[62:52]) - 1023;
			if (b[62:52] == 11'd0 || e < 0)
				mag = 64'd0;
			else if (e <= 52)
				mag = {12'd1, b[51:0]} >> (52 - e);
			else
				mag = {12'd1, b[51:0]} << (e - 52);
			return b[63] ? (64'd0 - mag) : mag;
		endfunction

		function bit pair_ok(logic [3:0] s, logic [3:0] t);
			if (s == t || t == TY_BOOL || s == TY_BOOL)
				return 1'b1;
			if ((fam_of[s] == FAM_FLT && fam_of[t] == FAM_SINT) ||
				(fam_of[s] == FAM_SINT && fam_of[t] == FAM_FLT))
				return 1'b1;
			if (fam_of[s] != fam_of[t])
				return 1'b0;
			return rank_of[t] >= rank_of[s];
		endfunction

		function conv_result_t convert(bit [63:0] v, bit last);
			conv_result_t r;
			logic [1:0]   sf;
			logic [1:0]   tf;
			bit [63:0]    d;
			r.bits = 64'd0;
			r.st = ST_OK;
			r.last = last;
			if (src_ty > TY_BOOL || dst_ty > TY_BOOL) begin
				r.st = ST_TRUNC;
				return r;
			end
			sf = fam_of[src_ty];
			tf = fam_of[dst_ty];
			// a bool target never mismatches on sign
			if (dst_ty == TY_BOOL)
				sf = tf;
			if ((sf == FAM_UINT || tf == FAM_UINT) && sf != tf) begin
				r.st = ST_SIGN;
			end else if (!pair_ok(src_ty, dst_ty)) begin
				r.st = ST_TRUNC;
			end else if (src_ty == dst_ty) begin
				case (fam_of[src_ty])
					FAM_SINT: r.bits = sext(v, width_of[src_ty]);
					FAM_BOOL: r.bits = {63'd0, v[0]};
					default:  r.bits = v & lmask(width_of[src_ty]);
				endcase
			end else begin
				d = src_to_dbl(src_ty, v);
				case (dst_ty)
					TY_F16: r.bits = dbl_to_narrow(d, 15, 5, 10);
					TY_F32: r.bits = dbl_to_narrow(d, 127, 8, 23);
					TY_F64: r.bits = d;
					TY_BOOL: r.bits = {63'd0, d[62:0] != 0};
					default: r.bits = dbl_to_int(d, width_of[dst_ty],
						fam_of[dst_ty] == FAM_SINT, r.st);
				endcase
			end
			return r;
		endfunction

		function void note_input(bit [63:0] v, bit last);
			due_q.push_back(convert(v, last));
		endfunction

		function void check_result(bit [63:0] bits, bit [1:0] st, bit last);
			conv_result_t e;
			results_seen++;
			if (due_q.size() == 0) begin
				$error("unexpected item: result_bits %h status %0d", bits, st);
				mismatches++;
				return;
			end
			e = due_q.pop_front();
			if (bits !== e.bits) begin
				$error("result_bits: expected %h, actual %h", e.bits, bits);
				mismatches++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				mismatches++;
			end
			if (last !== e.last) begin
				$error("last_out: expected %0d, actual %0d", e.last, last);
				mismatches++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	localparam int STUCK_LIMIT = 5000;
	localparam int LONG_BLOCK = 20;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] value_bits;
	logic        is_last;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_bits;
	logic [1:0]  status;
	logic        last_out;

	conv_scoreboard sb;
	bit             calm;
	bit             hold_on = 1'b0;
	bit             long_block = 1'b0;
	int             stuck_cycles = 0;

	numeric_dtype_converter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value_bits(value_bits),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_bits(result_bits),
		.status(status),
		.last_out(last_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(bit [63:0] v, bit last);
		in_valid <= 1'b1;
		value_bits <= v;
		is_last <= last;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(v, last);
	endtask

	task automatic sender_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_types(logic [3:0] s, logic [3:0] t);
		cfg_write <= 1'b1;
		cfg_index <= REG_SOURCE;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= REG_TARGET;
		cfg_data <= t;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_types(s, t);
	endtask

	// element generator biased toward range edges, NaN, infinity and saturation bounds
	function automatic bit [63:0] pick_element(logic [3:0] t);
		real       edges[20] = '{0.0, 1.0, -1.0, 0.5, -0.5, 127.5, -128.99, 255.9, 32767.5,
			-32768.7, 2147483647.0, -2147483649.0, 4294967296.0, 9.2233720368547758e18,
			-9.2233720368547758e18, 1.8446744073709552e19, 65504.0, 65520.0, 1.0e-8, 1.0e300};
		bit [63:0] odd[7] = '{64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h7FF4_0000_0000_0000,
			64'hFFF8_0000_0000_0000, 64'h0000_0000_0000_0001};
		bit [63:0] junk;
		bit [63:0] b;
		bit [63:0] v;
		bit [63:0] m;
		int        w;
		int        r;
		int        i;
		junk = {$urandom, $urandom};
		w = (t <= TY_BOOL) ? sb.width_of[t] : 64;
		m = sb.lmask(w);
		r = $urandom_range(0, 9);
		if (r < 3)
			return junk;
		if (t > TY_BOOL || t == TY_BOOL)
			return junk;
		if (sb.fam_of[t] == FAM_FLT) begin
			if (r < 6) begin
				i = $urandom_range(0, 26);
				b = (i < 20) ? $realtobits(edges[i]) : odd[i-20];
			end else begin
				b = {1'($urandom), 11'(1019 + $urandom_range(0, 70)), $urandom, 20'($urandom)};
			end
			case (t)
				TY_F16:  v = (r < 6) ? sb.dbl_to_narrow(b, 15, 5, 10) : junk;
				TY_F32:  v = sb.dbl_to_narrow(b, 127, 8, 23);
				default: v = b;
			endcase
		end else if (r < 6) begin
			case ($urandom_range(0, 4))
				0: v = 64'd0;
				1: v = 64'd1;
				2: v = '1;
				3: v = 64'd1 << (w - 1);
				default: v = (64'd1 << (w - 1)) - 64'd1;
			endcase
		end else begin
			v = junk >> $urandom_range(0, 63);
			if ($urandom_range(0, 1))
				v = 64'd0 - v;
		end
		// bits above the source width are don't-care
		return (v & m) | (junk & ~m);
	endfunction

	// receiver: random stall bursts plus one long hold-off to back up the pipeline
	initial begin
		int  stall_left;
		bit  held;
		stall_left = 0;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(result_bits, status, last_out);
			if (!held && long_block) begin
				held = 1'b1;
				hold_on = 1'b1;
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				hold_on = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[numeric_dtype_converter] ERROR");
			$finish;
		end
	end

	initial begin
		logic [3:0] src_q[$];
		logic [3:0] dst_q[$];
		int         order[$];
		int         n;
		int         k;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SOURCE;
		cfg_data = 4'd0;
		in_valid = 1'b0;
		value_bits = 64'd0;
		is_last = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// random items at the reset setting: f32 to f32 passthrough
		for (int i = 0; i < 12; i++)
			send_item(pick_element(TY_F32), i == 11);

		// every type pair in random order, then unknown codes, f16 to bool last
		for (int s = 0; s <= 11; s++)
			for (int t = 0; t <= 11; t++)
				order.push_back(s * 16 + t);
		order.shuffle();
		order.push_back(12 * 16 + 1);
		order.push_back(3 * 16 + 13);
		order.push_back(15 * 16 + 0);
		order.push_back(15 * 16 + 15);
		order.push_back(0 * 16 + 11);

		for (int p = 0; p < order.size(); p++) begin
			in_valid <= 1'b0;
			// idle before reconfiguring: wait out every pending item
			while (sb.pending() != 0)
				@(posedge clk);
			repeat (8) @(posedge clk);
			write_types(4'(order[p] / 16), 4'(order[p] % 16));
			calm = (p >= order.size() - 12) || ($urandom_range(0, 3) == 0);
			n = $urandom_range(8, 16);
			// one long block keeps offering items while the receiver holds off
			if (p == LONG_BLOCK) begin
				calm = 1'b1;
				n = 32;
				long_block = 1'b1;
			end
			for (k = 0; k < n; k++) begin
				if (!calm && !hold_on && $urandom_range(0, 4) == 0)
					sender_gap($urandom_range(1, 16));
				send_item(pick_element(sb.src_ty), $urandom_range(0, 7) == 0);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[numeric_dtype_converter] OK");
		else
			$display("[numeric_dtype_converter] ERROR");
		$finish;
	end

endmodule
